[design/box_boundary_wrap_reflect_top_assert.svh]
// Assertion macros for the box boundary block.
`ifndef BOX_BOUNDARY_WRAP_REFLECT_TOP_ASSERT_SVH
`define BOX_BOUNDARY_WRAP_REFLECT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBWR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBWR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBWR_ASSERT_IMP(lbl, ante, cons)
`define BBWR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/bbwr_pkg.sv]
// Shared types and constants of the box boundary block.
`default_nettype none
package bbwr_pkg;
  localparam int WORD_BITS = 32;
  localparam int SIZE_BITS = WORD_BITS - 1;
  localparam int DVD_BITS  = WORD_BITS + 1;
  localparam int EXT_BITS  = WORD_BITS + 2;
  localparam int DIV_STEPS = DVD_BITS;
  localparam int NUM_AXES  = 3;

  localparam logic [1:0] MODE_PERIODIC = 2'd0;
  localparam logic [1:0] MODE_REFLECT  = 2'd1;

  localparam logic [2:0] REG_SIZE_X  = 3'd0;
  localparam logic [2:0] REG_SIZE_Y  = 3'd1;
  localparam logic [2:0] REG_SIZE_Z  = 3'd2;
  localparam logic [2:0] REG_SHIFT_X = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z = 3'd5;
  localparam logic [2:0] REG_MODES   = 3'd6;

  typedef struct packed {
    logic [NUM_AXES-1:0][SIZE_BITS-1:0] size;
    logic [NUM_AXES-1:0][WORD_BITS-1:0] shift;
    logic [2*NUM_AXES-1:0]              modes;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pos;
    logic [WORD_BITS-1:0] vel;
    logic                 neg;
    logic                 hi;
    logic [DVD_BITS-1:0]  dvd;
    logic [SIZE_BITS-1:0] rem;
  } axis_t;

  typedef axis_t [NUM_AXES-1:0] stg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] np;
    logic [WORD_BITS-1:0] nv;
    logic                 chk;
    logic                 force_out;
  } res_axis_t;

  typedef res_axis_t [NUM_AXES-1:0] res_t;
endpackage
`default_nettype wire

[design/bbwr_div_cell.sv]
// One remainder step cell of the chain, one bit for each axis.
`default_nettype none
module bbwr_div_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 vld_i,
  input  wire bbwr_pkg::stg_t       data_i,
  input  wire bbwr_pkg::cfg_t       cfg_i,
  output logic                      vld_o,
  output bbwr_pkg::stg_t            data_o
);
  logic           vld_q;
  bbwr_pkg::stg_t data_d, data_q;

  always_comb begin
    logic [bbwr_pkg::SIZE_BITS:0] remn;
    data_d = data_i;
    for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
      remn = {data_i[k].rem, data_i[k].dvd[bbwr_pkg::DVD_BITS-1]};
      if (remn >= {1'b0, cfg_i.size[k]}) begin
        remn = remn - {1'b0, cfg_i.size[k]};
      end
      data_d[k].rem = remn[bbwr_pkg::SIZE_BITS-1:0];
      data_d[k].dvd = {data_i[k].dvd[bbwr_pkg::DVD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

[design/bbwr_fixup.sv]
// Turns the remainders into new positions and velocities.
`default_nettype none
module bbwr_fixup (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic           vld_i,
  input  wire bbwr_pkg::stg_t data_i,
  input  wire bbwr_pkg::cfg_t cfg_i,
  output logic                vld_o,
  output bbwr_pkg::res_t      res_o
);
  logic           vld_q;
  bbwr_pkg::res_t res_d, res_q;

  always_comb begin
    logic [bbwr_pkg::EXT_BITS-1:0] offw, lw, rw, ms, npw;
    logic [1:0] mode;
    logic       upd, hit;
    for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
      offw = {{2{cfg_i.shift[k][bbwr_pkg::WORD_BITS-1]}}, cfg_i.shift[k]};
      lw   = {3'b000, cfg_i.size[k]};
      rw   = {3'b000, data_i[k].rem};
      mode = cfg_i.modes[2*k +: 2];
      ms   = (data_i[k].neg && (rw != '0)) ? (lw - rw) : rw;
      upd  = 1'b0;
      hit  = 1'b0;
      npw  = '0;
      if (mode == bbwr_pkg::MODE_PERIODIC) begin
        upd = data_i[k].neg || data_i[k].hi;
        npw = ms - offw;
      end else begin
        hit = data_i[k].neg || data_i[k].hi;
        upd = hit;
        npw = data_i[k].neg ? (rw - offw) : (lw - rw - offw);
      end
      res_d[k].np = data_i[k].pos;
      res_d[k].nv = data_i[k].vel;
      res_d[k].chk = 1'b0;
      res_d[k].force_out = 1'b0;
      if (mode == bbwr_pkg::MODE_PERIODIC || mode == bbwr_pkg::MODE_REFLECT) begin
        if (cfg_i.size[k] == '0) begin
          res_d[k].force_out = 1'b1;
        end else begin
          res_d[k].chk = 1'b1;
          if (upd) begin
            if (npw[bbwr_pkg::EXT_BITS-1:bbwr_pkg::WORD_BITS-1] == 3'b000 ||
                npw[bbwr_pkg::EXT_BITS-1:bbwr_pkg::WORD_BITS-1] == 3'b111) begin
              res_d[k].np = npw[bbwr_pkg::WORD_BITS-1:0];
            end else begin
              res_d[k].np = npw[bbwr_pkg::EXT_BITS-1] ?
                  {1'b1, {(bbwr_pkg::WORD_BITS-1){1'b0}}} :
                  {1'b0, {(bbwr_pkg::WORD_BITS-1){1'b1}}};
            end
          end
          if (hit) begin
            if (data_i[k].vel == {1'b1, {(bbwr_pkg::WORD_BITS-1){1'b0}}}) begin
              res_d[k].nv = {1'b0, {(bbwr_pkg::WORD_BITS-1){1'b1}}};
            end else begin
              res_d[k].nv = '0 - data_i[k].vel;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

[design/box_boundary_wrap_reflect_top.sv]
// Top level of the 3-D periodic and reflective box boundary block.
// The block applies a box boundary rule to one particle per request, all values
// signed Q15.16. Each axis adds its center shift to the position and then, by its
// two-bit mode, wraps the coordinate into the box (periodic), folds it back and
// negates the velocity with saturation (reflective), or passes it (vacuum). The
// remainder of the shifted coordinate by the box size is found by a chain of 33
// identical cells, each resolving one bit for all three axes, followed by a fixup
// stage and the output register. A new request is taken every cycle while the
// output is not stalled, and a result passes the cells, the fixup stage and the
// output register in turn. Every stage has its own valid bit and loads whenever
// the stage after it is empty or moving, so bubbles close up and a stalled output
// holds back only as many requests as there are full stages. Configuration writes
// are always accepted and must only happen while the pipeline is empty; indexes
// beyond the register list are ignored.
`default_nettype none
`include "box_boundary_wrap_reflect_top_assert.svh"
module box_boundary_wrap_reflect_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [31:0] vel_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      new_pos_x_o,
  output logic [31:0]      new_pos_y_o,
  output logic [31:0]      new_pos_z_o,
  output logic [31:0]      new_vel_x_o,
  output logic [31:0]      new_vel_y_o,
  output logic [31:0]      new_vel_z_o,
  output logic [2:0]       outside_flags_o
);
  localparam int N = bbwr_pkg::DIV_STEPS;

  // Configuration registers.
  bbwr_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
        cfg_q.size[k]  <= bbwr_pkg::SIZE_BITS'(65536);
        cfg_q.shift[k] <= '0;
      end
      cfg_q.modes <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbwr_pkg::REG_SIZE_X:  cfg_q.size[0]  <= cfg_data_i[bbwr_pkg::SIZE_BITS-1:0];
        bbwr_pkg::REG_SIZE_Y:  cfg_q.size[1]  <= cfg_data_i[bbwr_pkg::SIZE_BITS-1:0];
        bbwr_pkg::REG_SIZE_Z:  cfg_q.size[2]  <= cfg_data_i[bbwr_pkg::SIZE_BITS-1:0];
        bbwr_pkg::REG_SHIFT_X: cfg_q.shift[0] <= cfg_data_i;
        bbwr_pkg::REG_SHIFT_Y: cfg_q.shift[1] <= cfg_data_i;
        bbwr_pkg::REG_SHIFT_Z: cfg_q.shift[2] <= cfg_data_i;
        bbwr_pkg::REG_MODES:   cfg_q.modes    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Entry: shifted coordinate, its sign, its magnitude and the high-side test.
  bbwr_pkg::stg_t entry;
  logic [2:0][31:0] pos_in, vel_in;

  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};
  assign vel_in = {vel_z_i, vel_y_i, vel_x_i};

  always_comb begin
    logic [bbwr_pkg::DVD_BITS-1:0] s;
    for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
      s = {pos_in[k][31], pos_in[k]} + {cfg_q.shift[k][31], cfg_q.shift[k]};
      entry[k].pos = pos_in[k];
      entry[k].vel = vel_in[k];
      entry[k].neg = s[bbwr_pkg::DVD_BITS-1];
      entry[k].hi  = !s[bbwr_pkg::DVD_BITS-1] && (s >= {2'b00, cfg_q.size[k]});
      entry[k].dvd = s[bbwr_pkg::DVD_BITS-1] ? ('0 - s) : s;
      entry[k].rem = '0;
    end
  end

  // Stage handshake: stage j loads when it is empty or the stage after it loads.
  // Stages 0..N-1 are the cells, stage N the fixup, stage N+1 the output register.
  logic [N+1:0] vld;
  logic [N+2:0] rdy;

  assign rdy[N+2] = out_ready_i;
  for (genvar j = 0; j <= N + 1; j++) begin : g_rdy
    assign rdy[j] = !vld[j] || rdy[j+1];
  end
  assign in_ready_o = rdy[0];

  bbwr_pkg::stg_t chain [N+1];
  assign chain[0] = entry;

  for (genvar j = 0; j < N; j++) begin : g_cell
    bbwr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (rdy[j]),
      .vld_i  ((j == 0) ? in_valid_i : vld[(j == 0) ? 0 : j-1]),
      .data_i (chain[j]),
      .cfg_i  (cfg_q),
      .vld_o  (vld[j]),
      .data_o (chain[j+1])
    );
  end

  bbwr_pkg::res_t fix_res;

  bbwr_fixup u_fixup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (rdy[N]),
    .vld_i  (vld[N-1]),
    .data_i (chain[N]),
    .cfg_i  (cfg_q),
    .vld_o  (vld[N]),
    .res_o  (fix_res)
  );

  // Output register, with the outside test of the delivered position.
  logic             out_vld_q;
  logic [2:0][31:0] np_q, nv_q;
  logic [2:0]       flags_q, flags_d;

  always_comb begin
    logic [bbwr_pkg::EXT_BITS-1:0] t;
    for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
      t = {{2{fix_res[k].np[31]}}, fix_res[k].np} +
          {{2{cfg_q.shift[k][31]}}, cfg_q.shift[k]};
      flags_d[k] = fix_res[k].force_out ||
          (fix_res[k].chk && (t[bbwr_pkg::EXT_BITS-1] || (t >= {3'b000, cfg_q.size[k]})));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[N+1]) begin
      out_vld_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N+1]) begin
      for (int k = 0; k < bbwr_pkg::NUM_AXES; k++) begin
        np_q[k] <= fix_res[k].np;
        nv_q[k] <= fix_res[k].nv;
      end
      flags_q <= flags_d;
    end
  end

  assign vld[N+1]        = out_vld_q;
  assign out_valid_o     = out_vld_q;
  assign new_pos_x_o     = np_q[0];
  assign new_pos_y_o     = np_q[1];
  assign new_pos_z_o     = np_q[2];
  assign new_vel_x_o     = nv_q[0];
  assign new_vel_y_o     = nv_q[1];
  assign new_vel_z_o     = nv_q[2];
  assign outside_flags_o = flags_q;

  // A stalled input can only come from a full pipeline behind a stalled output.
  `BBWR_ASSERT_IMP(a_stall_src, !in_ready_o, out_valid_o && !out_ready_i)
  // A vacuum x axis never reports outside.
  `BBWR_ASSERT_IMP(a_vac_x, out_valid_o && cfg_q.modes[1], !outside_flags_o[0])
  // A non-vacuum x axis with an empty box always reports outside.
  `BBWR_ASSERT_IMP(a_zero_x, out_valid_o && !cfg_q.modes[1] && (cfg_q.size[0] == '0),
                   outside_flags_o[0])
endmodule
`default_nettype wire
